@@ rtl/sll_pkg.sv @@
// Shared constants, types and codes of the sorted linked list engine.
package sll_pkg;

    localparam int NODES  = 64;                     // node pool depth
    localparam int LISTS  = 8;                      // sentinels 0 .. LISTS-1
    localparam int NODE_W = $clog2(NODES);
    localparam int LIST_W = 3;
    localparam int MEMB_W = $clog2(LISTS + 1);      // 0 = free, L+1 = list L
    localparam int KEY_W  = 32;
    localparam int CNT_W  = 6;
    localparam int STEP_W = $clog2(NODES + 1);

    typedef logic [NODE_W-1:0] node_t;
    typedef logic [LIST_W-1:0] lid_t;
    typedef logic [MEMB_W-1:0] memb_t;
    typedef logic [KEY_W-1:0]  key_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [STEP_W-1:0] step_t;

    typedef enum logic [2:0] {
        MODE_INIT_LIST  = 3'd0,
        MODE_INIT_ITEM  = 3'd1,
        MODE_APPEND     = 3'd2,
        MODE_PREPEND    = 3'd3,
        MODE_REMOVE     = 3'd4,
        MODE_INSERT_END = 3'd5,
        MODE_SORTED     = 3'd6,
        MODE_RSORTED    = 3'd7
    } mode_t;

    localparam logic ST_DONE    = 1'b0;
    localparam logic ST_IGNORED = 1'b1;

    typedef struct packed {
        mode_t mode;
        lid_t  list_id;
        node_t target_node;
        node_t item_node;
        key_t  item_key;
    } cmd_t;

    typedef struct packed {
        logic  status;
        cnt_t  list_size;
        node_t first_node;
    } res_t;

    // one read port and one write port, per-store write enables
    typedef struct packed {
        logic  rd_en;
        node_t rd_addr;
        logic  we_next;
        logic  we_prev;
        logic  we_key;
        logic  we_memb;
        node_t wr_addr;
        node_t wr_next;
        node_t wr_prev;
        key_t  wr_key;
        memb_t wr_memb;
    } mem_req_t;

    typedef struct packed {
        node_t next_node;
        node_t prev_node;
        key_t  key;
        memb_t memb;
    } mem_rsp_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_INIT_LIST,
        S_INIT_ITEM,
        S_ITEM_GET,
        S_DST_GET,
        S_WALK,
        S_LINK_W1,
        S_LINK_W2,
        S_LINK_W3,
        S_RM_GET,
        S_RM_W1,
        S_RM_W2,
        S_RM_W3,
        S_REPORT,
        S_RESULT
    } state_t;

endpackage

@@ rtl/sll_node_store.sv @@
// Node stores: next, prev, key and membership memories with registered read.
module sll_node_store
(
    input  logic             clk,
    input  logic             rst_n,
    input  sll_pkg::mem_req_t req,
    output sll_pkg::mem_rsp_t rsp
);

    sll_pkg::node_t next_mem [sll_pkg::NODES];
    sll_pkg::node_t prev_mem [sll_pkg::NODES];
    sll_pkg::key_t  key_mem  [sll_pkg::NODES];
    sll_pkg::memb_t memb_mem [sll_pkg::NODES];

    // key and membership reset to zero: written-since-reset flags
    logic [sll_pkg::NODES-1:0] key_vld_reg;
    logic [sll_pkg::NODES-1:0] memb_vld_reg;

    sll_pkg::node_t rd_next_reg;
    sll_pkg::node_t rd_prev_reg;
    sll_pkg::key_t  rd_key_reg;
    sll_pkg::memb_t rd_memb_reg;
    logic           rd_key_vld_reg;
    logic           rd_memb_vld_reg;

    always_ff @(posedge clk)
    begin
        if (req.we_next)
        begin
            next_mem[req.wr_addr] <= req.wr_next;
        end
        if (req.we_prev)
        begin
            prev_mem[req.wr_addr] <= req.wr_prev;
        end
        if (req.we_key)
        begin
            key_mem[req.wr_addr] <= req.wr_key;
        end
        if (req.we_memb)
        begin
            memb_mem[req.wr_addr] <= req.wr_memb;
        end
        if (req.rd_en)
        begin
            rd_next_reg     <= next_mem[req.rd_addr];
            rd_prev_reg     <= prev_mem[req.rd_addr];
            rd_key_reg      <= key_mem[req.rd_addr];
            rd_memb_reg     <= memb_mem[req.rd_addr];
            rd_key_vld_reg  <= key_vld_reg[req.rd_addr];
            rd_memb_vld_reg <= memb_vld_reg[req.rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_vld_reg  <= '0;
            memb_vld_reg <= '0;
        end
        else
        begin
            if (req.we_key)
            begin
                key_vld_reg[req.wr_addr] <= 1'b1;
            end
            if (req.we_memb)
            begin
                memb_vld_reg[req.wr_addr] <= 1'b1;
            end
        end
    end

    assign rsp.next_node = rd_next_reg;
    assign rsp.prev_node = rd_prev_reg;
    assign rsp.key       = rd_key_vld_reg  ? rd_key_reg  : '0;
    assign rsp.memb      = rd_memb_vld_reg ? rd_memb_reg : '0;

endmodule

@@ rtl/sll_ctrl.sv @@
// Operation sequencer: guards, sorted walk, link writes, list counts, result.
module sll_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  sll_pkg::cmd_t     cmd,
    output logic              busy,
    output logic              done,
    output sll_pkg::res_t     result,
    output sll_pkg::mem_req_t req,
    input  sll_pkg::mem_rsp_t rsp
);

    sll_pkg::state_t state_reg, state_next;
    sll_pkg::cmd_t   cmd_reg, cmd_next;
    sll_pkg::node_t  dst_reg, dst_next;       // link anchor / walk cursor / removed prev
    sll_pkg::node_t  nb_reg, nb_next;         // far neighbour of the anchor
    sll_pkg::memb_t  dmem_reg, dmem_next;
    sll_pkg::step_t  steps_reg, steps_next;
    logic            status_reg, status_next;
    logic            done_reg, done_next;
    sll_pkg::res_t   result_reg, result_next;

    sll_pkg::cnt_t   count_reg [sll_pkg::LISTS];
    logic            cnt_we;
    sll_pkg::lid_t   cnt_idx;
    sll_pkg::cnt_t   cnt_wdata;
    sll_pkg::cnt_t   cnt_rd;

    logic            lid_ok;
    logic            tgt_ok;
    logic            itm_ok;
    logic            is_sorted;
    logic            is_after;
    logic            key_pass;
    logic            dmem_ok;
    sll_pkg::memb_t  dmem_m1;
    sll_pkg::node_t  lid_node;

    assign lid_ok   = {1'b0, cmd_reg.list_id} < (sll_pkg::LIST_W + 1)'(sll_pkg::LISTS);
    assign tgt_ok   = {1'b0, cmd_reg.target_node} < (sll_pkg::NODE_W + 1)'(sll_pkg::NODES);
    assign itm_ok   = (cmd_reg.item_node >= sll_pkg::NODE_W'(sll_pkg::LISTS)) &&
                      ({1'b0, cmd_reg.item_node} < (sll_pkg::NODE_W + 1)'(sll_pkg::NODES));
    assign is_sorted = cmd_reg.mode inside {sll_pkg::MODE_SORTED, sll_pkg::MODE_RSORTED};
    assign is_after  = (cmd_reg.mode == sll_pkg::MODE_APPEND);
    assign key_pass  = (cmd_reg.mode == sll_pkg::MODE_SORTED) ? (rsp.key <= cmd_reg.item_key)
                                                               : (rsp.key >= cmd_reg.item_key);
    assign lid_node  = sll_pkg::NODE_W'(cmd_reg.list_id);
    assign dmem_m1   = dmem_reg - 1'b1;
    assign dmem_ok   = (dmem_reg != '0) && (dmem_m1 < sll_pkg::MEMB_W'(sll_pkg::LISTS));
    assign cnt_rd    = count_reg[cnt_idx];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sll_pkg::S_IDLE;
            done_reg  <= 1'b0;
            for (int i = 0; i < sll_pkg::LISTS; i++)
            begin
                count_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            if (cnt_we)
            begin
                count_reg[cnt_idx] <= cnt_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        dst_reg    <= dst_next;
        nb_reg     <= nb_next;
        dmem_reg   <= dmem_next;
        steps_reg  <= steps_next;
        status_reg <= status_next;
        result_reg <= result_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        dst_next    = dst_reg;
        nb_next     = nb_reg;
        dmem_next   = dmem_reg;
        steps_next  = steps_reg;
        status_next = status_reg;
        result_next = result_reg;
        done_next   = 1'b0;
        req         = '0;
        cnt_we      = 1'b0;
        cnt_idx     = cmd_reg.list_id;
        cnt_wdata   = cnt_rd;

        case (state_reg)
            sll_pkg::S_IDLE:
            begin
                if (start)
                begin
                    cmd_next   = cmd;
                    state_next = sll_pkg::S_CHECK;
                end
            end

            sll_pkg::S_CHECK:
            begin
                status_next = sll_pkg::ST_IGNORED;
                state_next  = sll_pkg::S_REPORT;
                case (cmd_reg.mode)
                    sll_pkg::MODE_INIT_LIST:
                    begin
                        if (lid_ok)
                        begin
                            state_next = sll_pkg::S_INIT_LIST;
                        end
                    end
                    sll_pkg::MODE_INIT_ITEM:
                    begin
                        if (itm_ok)
                        begin
                            state_next = sll_pkg::S_INIT_ITEM;
                        end
                    end
                    sll_pkg::MODE_APPEND, sll_pkg::MODE_PREPEND:
                    begin
                        if (tgt_ok && itm_ok)
                        begin
                            dst_next    = cmd_reg.target_node;
                            req.rd_en   = 1'b1;
                            req.rd_addr = cmd_reg.item_node;
                            state_next  = sll_pkg::S_ITEM_GET;
                        end
                    end
                    sll_pkg::MODE_REMOVE:
                    begin
                        if (itm_ok)
                        begin
                            req.rd_en   = 1'b1;
                            req.rd_addr = cmd_reg.item_node;
                            state_next  = sll_pkg::S_RM_GET;
                        end
                    end
                    sll_pkg::MODE_INSERT_END, sll_pkg::MODE_SORTED, sll_pkg::MODE_RSORTED:
                    begin
                        if (lid_ok && itm_ok)
                        begin
                            dst_next    = lid_node;
                            req.rd_en   = 1'b1;
                            req.rd_addr = cmd_reg.item_node;
                            state_next  = sll_pkg::S_ITEM_GET;
                        end
                    end
                    default:
                    begin
                        state_next = sll_pkg::S_REPORT;
                    end
                endcase
            end

            sll_pkg::S_INIT_LIST:
            begin
                req.we_next = 1'b1;
                req.we_prev = 1'b1;
                req.we_key  = 1'b1;
                req.we_memb = 1'b1;
                req.wr_addr = lid_node;
                req.wr_next = lid_node;
                req.wr_prev = lid_node;
                req.wr_key  = '0;
                req.wr_memb = sll_pkg::MEMB_W'(cmd_reg.list_id) + 1'b1;
                cnt_we      = 1'b1;
                cnt_wdata   = '0;
                status_next = sll_pkg::ST_DONE;
                state_next  = sll_pkg::S_REPORT;
            end

            sll_pkg::S_INIT_ITEM:
            begin
                req.we_key  = 1'b1;
                req.we_memb = 1'b1;
                req.wr_addr = cmd_reg.item_node;
                req.wr_key  = '0;
                req.wr_memb = '0;
                status_next = sll_pkg::ST_DONE;
                state_next  = sll_pkg::S_REPORT;
            end

            sll_pkg::S_ITEM_GET:
            begin
                // item must be free
                if (rsp.memb != '0)
                begin
                    state_next = sll_pkg::S_REPORT;
                end
                else
                begin
                    req.rd_en   = 1'b1;
                    req.rd_addr = dst_reg;
                    state_next  = sll_pkg::S_DST_GET;
                end
            end

            sll_pkg::S_DST_GET:
            begin
                if (rsp.memb == '0)
                begin
                    state_next = sll_pkg::S_REPORT;
                end
                else if (is_sorted)
                begin
                    dst_next    = rsp.next_node;
                    steps_next  = '0;
                    req.rd_en   = 1'b1;
                    req.rd_addr = rsp.next_node;
                    state_next  = sll_pkg::S_WALK;
                end
                else
                begin
                    dmem_next  = rsp.memb;
                    nb_next    = is_after ? rsp.next_node : rsp.prev_node;
                    state_next = sll_pkg::S_LINK_W1;
                end
            end

            sll_pkg::S_WALK:
            begin
                // rsp holds the node under the cursor; equal keys are passed
                if ((dst_reg != lid_node) && (steps_reg < sll_pkg::STEP_W'(sll_pkg::NODES))
                    && key_pass)
                begin
                    dst_next    = rsp.next_node;
                    steps_next  = steps_reg + 1'b1;
                    req.rd_en   = 1'b1;
                    req.rd_addr = rsp.next_node;
                end
                else if (rsp.memb == '0)
                begin
                    state_next = sll_pkg::S_REPORT;
                end
                else
                begin
                    dmem_next  = rsp.memb;
                    nb_next    = rsp.prev_node;
                    state_next = sll_pkg::S_LINK_W1;
                end
            end

            sll_pkg::S_LINK_W1:
            begin
                req.wr_addr = dst_reg;
                req.we_next = is_after;
                req.we_prev = !is_after;
                req.wr_next = cmd_reg.item_node;
                req.wr_prev = cmd_reg.item_node;
                state_next  = sll_pkg::S_LINK_W2;
            end

            sll_pkg::S_LINK_W2:
            begin
                req.wr_addr = cmd_reg.item_node;
                req.we_next = 1'b1;
                req.we_prev = 1'b1;
                req.we_memb = 1'b1;
                req.we_key  = is_sorted;
                req.wr_next = is_after ? nb_reg : dst_reg;
                req.wr_prev = is_after ? dst_reg : nb_reg;
                req.wr_memb = dmem_reg;
                req.wr_key  = cmd_reg.item_key;
                state_next  = sll_pkg::S_LINK_W3;
            end

            sll_pkg::S_LINK_W3:
            begin
                req.wr_addr = nb_reg;
                req.we_next = !is_after;
                req.we_prev = is_after;
                req.wr_next = cmd_reg.item_node;
                req.wr_prev = cmd_reg.item_node;
                cnt_idx     = dmem_m1[sll_pkg::LIST_W-1:0];
                cnt_we      = dmem_ok && (cnt_rd != '1);
                cnt_wdata   = cnt_rd + 1'b1;
                status_next = sll_pkg::ST_DONE;
                state_next  = sll_pkg::S_REPORT;
            end

            sll_pkg::S_RM_GET:
            begin
                if (rsp.memb == '0)
                begin
                    state_next = sll_pkg::S_REPORT;
                end
                else
                begin
                    dst_next   = rsp.prev_node;
                    nb_next    = rsp.next_node;
                    dmem_next  = rsp.memb;
                    state_next = sll_pkg::S_RM_W1;
                end
            end

            sll_pkg::S_RM_W1:
            begin
                req.wr_addr = dst_reg;
                req.we_next = 1'b1;
                req.wr_next = nb_reg;
                state_next  = sll_pkg::S_RM_W2;
            end

            sll_pkg::S_RM_W2:
            begin
                req.wr_addr = nb_reg;
                req.we_prev = 1'b1;
                req.wr_prev = dst_reg;
                cnt_idx     = dmem_m1[sll_pkg::LIST_W-1:0];
                cnt_we      = dmem_ok && (cnt_rd != '0);
                cnt_wdata   = cnt_rd - 1'b1;
                state_next  = sll_pkg::S_RM_W3;
            end

            sll_pkg::S_RM_W3:
            begin
                req.wr_addr = cmd_reg.item_node;
                req.we_memb = 1'b1;
                req.wr_memb = '0;
                status_next = sll_pkg::ST_DONE;
                state_next  = sll_pkg::S_REPORT;
            end

            sll_pkg::S_REPORT:
            begin
                req.rd_en   = lid_ok;
                req.rd_addr = lid_node;
                state_next  = sll_pkg::S_RESULT;
            end

            sll_pkg::S_RESULT:
            begin
                result_next.status = status_reg;
                if (lid_ok)
                begin
                    result_next.list_size  = cnt_rd;
                    result_next.first_node = (rsp.memb != '0) ? rsp.next_node : lid_node;
                end
                else
                begin
                    result_next.list_size  = '0;
                    result_next.first_node = '0;
                end
                done_next  = 1'b1;
                state_next = sll_pkg::S_IDLE;
            end

            default:
            begin
                state_next = sll_pkg::S_IDLE;
            end
        endcase
    end

    assign busy   = (state_reg != sll_pkg::S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule

@@ rtl/sorted_linked_list_engine_top.sv @@
// Top level of the sorted linked list engine: sequencer plus node stores.
// Sorted insert walks past up to 64 nodes (equal keys are passed) before linking;
//   guard failures end an operation early.
// Throughput: one operation at a time; a transfer may be accepted in
//   the cycle that shows the done strobe. Results are strobes: the receiver cannot stall.
// Reset (rst_n, async, active low) idles the sequencer, clears counts, zeroes keys/membership.
module sorted_linked_list_engine_top
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  sll_pkg::cmd_t cmd,
    output logic          busy,
    output logic          done,
    output sll_pkg::res_t result
);

    // one shared read port feeds all four stores; writes go to a single address
    // per cycle, so every link update is a short run of write cycles
    sll_pkg::mem_req_t mem_req;
    sll_pkg::mem_rsp_t mem_rsp;

    // sequencer: latches the transfer, checks guards, walks the list and
    // issues the link writes in order: anchor, new item, far neighbour
    sll_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done),
        .result (result),
        .req    (mem_req),
        .rsp    (mem_rsp)
    );

    // node stores: read data is registered, reads and writes never share a cycle
    sll_node_store u_store
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mem_req),
        .rsp   (mem_rsp)
    );

endmodule

@@ rtl/sll_checker.sv @@
// Port-level checks of the engine's command and result timing, bound to the top.
module sll_checker
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done
);

    // an accepted transfer keeps the engine busy in the next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("engine not busy after an accepted transfer");

    // the result strobe only shows once the engine has gone idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    // busy ends exactly with the result of that operation
    a_fall_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("busy dropped without a result");

    // exactly one result per operation
    a_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for more than one cycle");

    // a result is only produced if a transfer was accepted before it
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result without an operation in flight");

endmodule

bind sorted_linked_list_engine_top sll_checker u_sll_checker
(
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done)
);
